// ===== src/dotq_pkg.sv =====
// Shared types, constants and codes for the deadline-ordered task queue.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package dotq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int DEADLINE_BITS = 16;
    localparam int ID_W          = 8;
    localparam int DL_FIELD_W    = 16;
    localparam int IDX_W         = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_EDF  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Control broadcast to every cell of the chain for one transfer.
    typedef struct packed {
        logic                     insert;
        logic                     remove;
        logic                     edf;
        logic [ID_W-1:0]          new_id;
        logic [DEADLINE_BITS-1:0] new_dl;
        logic [COUNT_W-1:0]       count;
    } dotq_ctl_t;

    // Contents of one queue slot.
    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [DEADLINE_BITS-1:0] dl;
    } dotq_entry_t;

endpackage

// ===== src/deadline_ordered_task_queue.sv =====
// Top level of the deadline-ordered task queue: stream ports, count, result register.
// Depends on dotq_pkg and dotq_cell.
`timescale 1ns / 1ps

// Channel      | Signals                          | Contents
// -------------+----------------------------------+--------------------------------------
// input        | s_tvalid s_tready s_tdata s_tuser | task_id, deadline; tuser = command
// result       | m_tvalid m_tready m_tdata m_tuser | head_task_id, head_deadline,
//              |                                  | entry_count; tuser = status
// config       | cfg_we cfg_wdata                 | order_mode
//
// On every transfer all cells of the chain compare their deadline with the new one,
// a prefix OR ripples along the chain to mark the insert point, and each cell loads
// the new task, its left neighbor, its right neighbor or itself at the same edge.
// One item per cycle is sustained while the output result is not stalled.
// The result appears in the output register on the cycle after the transfer.
// Reset clears the entry count, the mode and the output valid; slot contents
// are left as they are. A stalled result holds, and the input is taken again
// in the same cycle that the pending result is taken.

module deadline_ordered_task_queue
    import dotq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,    // order_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // [7:0] task_id, [23:8] deadline
    input  logic        s_tuser,      // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // [7:0] head_task_id, [23:8] head_deadline,
                                      // [28:24] entry_count, rest zero
    output logic [1:0]  m_tuser       // [1:0] status
);

    logic                     mode_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic                     m_valid_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic [ID_W-1:0]          head_id_reg;
    logic [ID_W-1:0]          head_id_next;
    logic [DL_FIELD_W-1:0]    head_dl_reg;
    logic [DL_FIELD_W-1:0]    head_dl_next;
    logic [COUNT_W-1:0]       out_count_reg;

    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    dotq_ctl_t                ctl;
    dotq_entry_t              entries [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]     found;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_full  = count_reg == COUNT_W'(QUEUE_DEPTH);
    assign is_empty = count_reg == '0;

    // The cells only move when the operation really changes the queue.
    assign ctl.insert = accept && (s_tuser == CMD_INSERT) && !is_full;
    assign ctl.remove = accept && (s_tuser == CMD_REMOVE) && !is_empty;
    assign ctl.edf    = mode_reg == MODE_EDF;
    assign ctl.new_id = s_tdata[7:0];
    assign ctl.new_dl = s_tdata[8 +: DEADLINE_BITS];
    assign ctl.count  = count_reg;

    assign found[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        dotq_entry_t left_entry;
        dotq_entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_entry = '0;
        end
        else
        begin : g_mid
            assign left_entry = entries[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = entries[i];
        end
        else
        begin : g_body
            assign right_entry = entries[i+1];
        end

        dotq_cell u_cell (
            .clk         (clk),
            .cell_idx    (IDX_W'(i)),
            .ctl         (ctl),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .found_in    (found[i]),
            .found_out   (found[i+1]),
            .entry       (entries[i])
        );
    end

    always_comb
    begin
        count_next   = count_reg;
        status_next  = ST_DONE;
        head_id_next = '0;
        head_dl_next = '0;
        if (s_tuser == CMD_REMOVE)
        begin
            if (is_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                head_id_next = entries[0].id;
                head_dl_next = DL_FIELD_W'(entries[0].dl);
                count_next   = count_reg - COUNT_W'(1);
            end
        end
        else if (is_full)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_FIFO;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            head_id_reg   <= head_id_next;
            head_dl_reg   <= head_dl_next;
            out_count_reg <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, COUNT_FIELD_W'(out_count_reg), head_dl_reg, head_id_reg};

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // A refused insert or an empty remove leaves the count alone.
    a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((s_tuser == CMD_INSERT && is_full) ||
                    (s_tuser == CMD_REMOVE && is_empty))) |=> $stable(count_reg))
        else $error("count moved on a refused transfer");

    // A result reporting an empty queue carries a zero count.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && status_reg == ST_EMPTY) |-> (out_count_reg == '0))
        else $error("empty status with nonzero count");

    // A taken insert always raises the count by one.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("insert did not grow the queue");

    // While a slot is free the chain always finds an insert point.
    a_insert_point: assert property (@(posedge clk) disable iff (!rst_n)
        !is_full |-> found[QUEUE_DEPTH])
        else $error("no insert point found with a free slot");

endmodule

// ===== src/dotq_cell.sv =====
// One slot of the queue chain: holds a task and compares it with a new one.
// Depends on dotq_pkg.
`timescale 1ns / 1ps

module dotq_cell
    import dotq_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] cell_idx,
    input  dotq_ctl_t        ctl,
    input  dotq_entry_t      left_entry,
    input  dotq_entry_t      right_entry,
    input  logic             found_in,
    output logic             found_out,
    output dotq_entry_t      entry
);

    dotq_entry_t entry_reg;
    dotq_entry_t entry_next;
    logic        occupied;
    logic        hit;

    // A free slot always accepts; an occupied slot only in EDF mode on a later deadline.
    assign occupied  = COUNT_W'(cell_idx) < ctl.count;
    assign hit       = occupied ? (ctl.edf && (entry_reg.dl > ctl.new_dl)) : 1'b1;
    assign found_out = found_in | hit;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.remove)
        begin
            entry_next = right_entry;
        end
        else if (ctl.insert)
        begin
            if (found_in)
            begin
                entry_next = left_entry;
            end
            else if (hit)
            begin
                entry_next.id = ctl.new_id;
                entry_next.dl = ctl.new_dl;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
